// ===== hdl/lruc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lruc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                    rotate;    // shift contents one cell toward the head
    logic                    apply;     // commit the decided update this cycle
    logic                    age_all;   // every other valid entry ages (insert)
    logic                    wr_entry;  // selected cell takes key and value
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lruc_if.sv =====
// Request and result channel interfaces for the LRU key-value cache.
`default_nettype none

interface lruc_req_if;
  import lruc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, command, lookup_key, write_value, input ready);
  modport sink   (input valid, command, lookup_key, write_value, output ready);
endinterface

interface lruc_rsp_if;
  import lruc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: controller plus a rotating row of cells.
`default_nettype none

// Fully associative key/value store of MAX_ENTRIES entries kept in
// least-recently-used order. A get (command 0) returns found=1 and the stored
// value on a hit and makes that entry most recent; a miss returns found=0 and
// read_value all ones. A put (command 1) updates a present key or inserts a new
// one, evicting the least recent entry when the store holds capacity_in_use
// entries or more (0 acts as 1, values above MAX_ENTRIES act as MAX_ENTRIES);
// a put returns no transaction. Recency is a per-entry rank, 0 = most recent.
// Storage is a ring of identical cells. After an input transaction is taken the
// ring rotates one cell per cycle through a full turn while a single compare
// unit at the head looks for the key, the oldest entry and a free cell; the
// ring is then back in place and a single broadcast updates every cell at once.
// The input is ready only in idle, so a new transaction is taken only after the
// last one's update. A get result sits in an output register, so the next
// transaction can be taken and scanned while it waits; a second get holds in
// its update cycle until that register frees. capacity_in_use must be written
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
// Reset leaves the store empty; no clearing pass is needed.

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  lruc_req_if.sink                        in_ch,
  lruc_rsp_if.source                      out_ch,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lruc_pkg::CAP_W-1:0] cfg_wr_data
);
  import lruc_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW = IW;
  localparam int OW = $clog2(MAX_ENTRIES + 1);

  cell_ctl_t               ctl;
  logic [IW-1:0]           tgt_idx;
  logic [RW-1:0]           hit_rank;

  logic                    c_valid [MAX_ENTRIES];
  logic signed [KEY_W-1:0] c_key   [MAX_ENTRIES];
  logic signed [VAL_W-1:0] c_value [MAX_ENTRIES];
  logic [RW-1:0]           c_rank  [MAX_ENTRIES];

  lruc_ctrl #(
    .N  (MAX_ENTRIES),
    .IW (IW),
    .RW (RW),
    .OW (OW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_valid  (c_valid[0]),
    .head_key    (c_key[0]),
    .head_value  (c_value[0]),
    .head_rank   (c_rank[0]),
    .ctl         (ctl),
    .tgt_idx     (tgt_idx),
    .hit_rank    (hit_rank)
  );

  // Cell i takes from cell i+1 on rotate; the last cell wraps from the head.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_ENTRIES;
    logic sel;
    assign sel = (tgt_idx == IW'(i));

    lruc_cell #(
      .RW (RW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sel      (sel),
      .hit_rank (hit_rank),
      .nb_valid (c_valid[NB]),
      .nb_key   (c_key[NB]),
      .nb_value (c_value[NB]),
      .nb_rank  (c_rank[NB]),
      .valid    (c_valid[i]),
      .key      (c_key[i]),
      .value    (c_value[i]),
      .rank     (c_rank[i])
    );
  end

endmodule

`default_nettype wire

// ===== hdl/lruc_cell.sv =====
// One storage cell of the LRU row: valid, key, value and recency rank.
`default_nettype none

module lruc_cell #(
  parameter int RW = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lruc_pkg::cell_ctl_t             ctl,
  input  wire logic                            sel,
  input  wire logic [RW-1:0]                   hit_rank,
  input  wire logic                            nb_valid,
  input  wire logic signed [lruc_pkg::KEY_W-1:0] nb_key,
  input  wire logic signed [lruc_pkg::VAL_W-1:0] nb_value,
  input  wire logic [RW-1:0]                   nb_rank,
  output logic                                 valid,
  output logic signed [lruc_pkg::KEY_W-1:0]    key,
  output logic signed [lruc_pkg::VAL_W-1:0]    value,
  output logic [RW-1:0]                        rank
);
  import lruc_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic [RW-1:0]           rank_r, rank_nxt;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    rank_nxt  = rank_r;
    if (ctl.rotate) begin
      valid_nxt = nb_valid;
      key_nxt   = nb_key;
      value_nxt = nb_value;
      rank_nxt  = nb_rank;
    end else if (ctl.apply) begin
      if (sel) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        if (ctl.wr_entry) begin
          key_nxt   = ctl.key;
          value_nxt = ctl.value;
        end
      end else if (valid_r && (ctl.age_all || (rank_r < hit_rank))) begin
        rank_nxt = rank_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;
  assign rank  = rank_r;

endmodule

`default_nettype wire

// ===== hdl/lruc_ctrl.sv =====
// Sequencer: scans the cell row at its head, decides the update, drives results.
`default_nettype none

module lruc_ctrl #(
  parameter int N  = 16,
  parameter int IW = 4,
  parameter int RW = 4,
  parameter int OW = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lruc_req_if.sink                               in_ch,
  lruc_rsp_if.source                             out_ch,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lruc_pkg::CAP_W-1:0]        cfg_wr_data,
  input  wire logic                              head_valid,
  input  wire logic signed [lruc_pkg::KEY_W-1:0] head_key,
  input  wire logic signed [lruc_pkg::VAL_W-1:0] head_value,
  input  wire logic [RW-1:0]                     head_rank,
  output lruc_pkg::cell_ctl_t                    ctl,
  output logic [IW-1:0]                          tgt_idx,
  output logic [RW-1:0]                          hit_rank
);
  import lruc_pkg::*;

  localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;

  state_t                  state_r, state_nxt;
  logic [IW-1:0]           pos_r, pos_nxt;
  logic                    cmd_r, cmd_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    found_r, found_nxt;
  logic [IW-1:0]           hit_idx_r, hit_idx_nxt;
  logic [RW-1:0]           hit_rank_r, hit_rank_nxt;
  logic signed [VAL_W-1:0] hit_val_r, hit_val_nxt;
  logic [IW-1:0]           old_idx_r, old_idx_nxt;
  logic [IW-1:0]           free_idx_r, free_idx_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [OW-1:0]           occ_r, occ_nxt;
  logic [CAP_W-1:0]        cap_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic                    evict;

  // Full when occupancy reaches the capacity in use (zero counts as one) or the row size.
  assign evict = (occ_r != '0) &&
                 ((CMPW'(occ_r) >= CMPW'(cap_r)) || (occ_r == OW'(N)));

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rank_nxt   = hit_rank_r;
    hit_val_nxt    = hit_val_r;
    old_idx_nxt    = old_idx_r;
    free_idx_nxt   = free_idx_r;
    free_found_nxt = free_found_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_val_nxt    = out_val_r;
    in_ch.ready    = 1'b0;

    ctl          = '0;
    ctl.key      = key_r;
    ctl.value    = val_r;
    hit_rank     = hit_rank_r;
    tgt_idx      = found_r ? hit_idx_r : (evict ? old_idx_r : free_idx_r);

    case (state_r)
      ST_IDLE: begin
        // no transaction is taken while reset is held
        in_ch.ready = rst_n;
        if (in_ch.valid) begin
          cmd_nxt        = in_ch.command;
          key_nxt        = in_ch.lookup_key;
          val_nxt        = in_ch.write_value;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          pos_nxt        = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.rotate = 1'b1;
        if (head_valid && (head_key == key_r) && !found_r) begin
          found_nxt    = 1'b1;
          hit_idx_nxt  = pos_r;
          hit_rank_nxt = head_rank;
          hit_val_nxt  = head_value;
        end
        if (head_valid && (head_rank == RW'(occ_r - OW'(1)))) begin
          old_idx_nxt = pos_r;
        end
        if (!head_valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = pos_r;
        end
        if (pos_r == IW'(N - 1)) begin
          state_nxt = ST_UPDATE;
        end else begin
          pos_nxt = pos_r + IW'(1);
        end
      end
      ST_UPDATE: begin
        if (cmd_r == CMD_GET) begin
          if (!out_valid_r || out_ch.ready) begin
            ctl.apply     = found_r;
            out_valid_nxt = 1'b1;
            out_found_nxt = found_r;
            out_val_nxt   = found_r ? hit_val_r : MISS_VALUE;
            state_nxt     = ST_IDLE;
          end
        end else begin
          ctl.apply    = 1'b1;
          ctl.wr_entry = 1'b1;
          ctl.age_all  = !found_r;
          if (!found_r && !evict) begin
            occ_nxt = occ_r + OW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
    pos_r        <= pos_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_rank_r   <= hit_rank_nxt;
    hit_val_r    <= hit_val_nxt;
    old_idx_r    <= old_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    free_found_r <= free_found_nxt;
    out_found_r  <= out_found_nxt;
    out_val_r    <= out_val_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.read_value = out_val_r;

endmodule

`default_nettype wire

// ===== verif/lru_key_value_cache_tb.sv =====
// Testbench for the LRU key-value cache: random get/put traffic checked against a recency model.
`default_nettype none

module lru_key_value_cache_tb;
  import lruc_pkg::*;

  localparam int SLOTS         = 16;           // MAX_ENTRIES of the instance
  localparam int SETTLE_CYCLES = 2*SLOTS + 8;  // a put in flight gives no transaction
  localparam int CYCLE_LIMIT   = 150000;

  typedef struct {
    logic                    command;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct {
    logic                    found;
    logic signed [VAL_W-1:0] value;
  } rsp_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  lruc_req_if req_ch ();
  lruc_rsp_if rsp_ch ();

  lru_key_value_cache #(.MAX_ENTRIES(SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Stimulus queue, pending lookup results and bookkeeping.
  req_t req_queue[$];
  rsp_t lookup_results[$];
  req_t cur_req;
  int   reqs_queued   = 0;
  int   reqs_taken    = 0;
  int   err_count     = 0;
  int   send_idle_pct = 34;
  int   recv_idle_pct = 34;
  int   rx_hold       = 0;   // cycles the receiver still holds ready low
  int   cycle_count   = 0;

  // Cache shadow: per-slot contents and recency rank (0 = most recent).
  logic                    slot_valid [SLOTS];
  logic signed [KEY_W-1:0] slot_key   [SLOTS];
  logic signed [VAL_W-1:0] slot_val   [SLOTS];
  int                      slot_rank  [SLOTS];
  int                      fill_count;
  logic [CAP_W-1:0]        cap_reg;

  // Entries more recent than idx age by one; idx becomes most recent.
  function automatic void make_recent(input int idx);
    int r;
    r = slot_rank[idx];
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[idx] = 0;
  endfunction

  // Apply one accepted transaction to the shadow; a get queues its lookup result.
  function automatic void cache_access(input req_t r);
    int   hit;
    int   victim;
    int   eff_cap;
    rsp_t rsp;
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && slot_valid[i] && slot_key[i] == r.key) hit = i;

    if (r.command == CMD_GET) begin
      if (hit >= 0) begin
        make_recent(hit);
        rsp.found = 1'b1;
        rsp.value = slot_val[hit];
      end else begin
        rsp.found = 1'b0;
        rsp.value = MISS_VALUE;
      end
      lookup_results.push_back(rsp);
    end else if (hit >= 0) begin
      // update in place, never evicts
      slot_val[hit] = r.value;
      make_recent(hit);
    end else begin
      eff_cap = (cap_reg == 0) ? 1 : (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
      victim  = -1;
      // full at the capacity in use: drop the least recent entry first
      if (fill_count >= eff_cap) begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        if (victim >= 0) begin
          slot_valid[victim] = 1'b0;
          fill_count--;
        end
      end
      if (victim < 0)
        for (int i = 0; i < SLOTS; i++)
          if (victim < 0 && !slot_valid[i]) victim = i;
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i]) slot_rank[i]++;
      slot_valid[victim] = 1'b1;
      slot_key[victim]   = r.key;
      slot_val[victim]   = r.value;
      slot_rank[victim]  = 0;
      fill_count++;
    end
  endfunction

  // Driver: offers the next queued request; valid holds until the transaction completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        cache_access(cur_req);
        reqs_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req             = req_queue.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.command     <= cur_req.command;
          req_ch.lookup_key  <= cur_req.key;
          req_ch.write_value <= cur_req.value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest pending lookup.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (lookup_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual found=%0b value=%h",
                   $time, rsp_ch.found, rsp_ch.read_value);
        end else begin
          want = lookup_results.pop_front();
          if (rsp_ch.found !== want.found) begin
            err_count++;
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, rsp_ch.found);
          end
          if (rsp_ch.read_value !== want.value) begin
            err_count++;
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, want.value, rsp_ch.read_value);
          end
        end
      end
      // long hold-off backs the cache up until its input stalls
      if (rx_hold > 0) begin
        rx_hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lru_key_value_cache_tb: done, errors");
      $finish;
    end
  end

  task automatic queue_req(input logic cmd, input logic signed [KEY_W-1:0] key,
                           input logic signed [VAL_W-1:0] value);
    req_t r;
    r.command = cmd;
    r.key     = key;
    r.value   = value;
    req_queue.push_back(r);
    reqs_queued++;
  endtask

  // Keys mostly from a small pool so gets hit and puts evict; the rest are stray keys.
  task automatic queue_random(input int n, input int pool_size);
    logic signed [KEY_W-1:0] pool [32];
    for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
    for (int i = 0; i < n; i++)
      queue_req(1'($urandom_range(1)),
                ($urandom_range(99) < 88) ? pool[$urandom_range(pool_size-1)] : $urandom,
                $urandom);
  endtask

  // Sender pauses until everything was taken and answered, then lets puts settle.
  task automatic drain();
    while (reqs_taken != reqs_queued || lookup_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity is only written while the cache is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_reg      = cap;
  endtask

  initial begin
    int rnd_cap;
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_GET;
    req_ch.lookup_key  = '0;
    req_ch.write_value = '0;
    rsp_ch.ready       = 1'b0;
    cap_reg            = CAP_RESET;
    fill_count         = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_rank[i]  = 0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capacity: empty store, key and value extremes, update, near-miss key.
    queue_req(CMD_GET, 32'sd0, 32'sd5);                          // get on empty store
    queue_req(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(CMD_PUT, 32'sd0, 32'sd0);
    queue_req(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);            // hit value equals miss value
    queue_req(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_req(CMD_GET, 32'h8000_0000, 32'sd0);
    queue_req(CMD_GET, 32'sd0, 32'sd0);
    queue_req(CMD_GET, 32'hFFFF_FFFF, 32'sd0);
    queue_req(CMD_GET, 32'h7FFF_FFFE, 32'sd0);                   // one bit off: miss
    queue_req(CMD_PUT, 32'sd0, 32'h1234_5678);
    queue_req(CMD_GET, 32'sd0, 32'h5555_AAAA);
    queue_req(CMD_GET, 32'h0000_0001, 32'hAAAA_5555);
    drain();

    // Capacity zero acts as one: every new key evicts, an update does not.
    write_capacity(5'd0);
    queue_req(CMD_PUT, 32'h0BAD_CAFE, 32'sd11);
    queue_req(CMD_PUT, 32'h1BAD_CAFE, 32'sd22);
    queue_req(CMD_GET, 32'h0BAD_CAFE, 32'sd0);
    queue_req(CMD_GET, 32'h1BAD_CAFE, 32'sd0);
    queue_req(CMD_PUT, 32'h1BAD_CAFE, 32'sd33);
    queue_req(CMD_GET, 32'h1BAD_CAFE, 32'sd0);
    drain();

    // All ones saturates to the full store; pool larger than the store.
    write_capacity(5'd31);
    queue_random(90, 24);
    drain();

    // Capacity lowered below occupancy: new keys replace, occupancy holds.
    write_capacity(5'd3);
    queue_random(60, 8);
    drain();

    // No idling at all, and the receiver stalls long enough to back up the input.
    write_capacity(5'd16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold       = 300;
    queue_random(100, 20);
    drain();
    send_idle_pct = 34;
    recv_idle_pct = 34;

    write_capacity(5'd1);
    queue_random(60, 4);
    drain();

    write_capacity(5'd17);
    queue_random(80, 20);
    drain();

    rnd_cap = $urandom_range(16, 1);
    write_capacity(rnd_cap[CAP_W-1:0]);
    queue_random(80, rnd_cap + 4);
    drain();

    write_capacity(5'd8);
    queue_random(80, 12);
    drain();

    if (err_count == 0) begin
      $display("lru_key_value_cache_tb: done, clean");
    end else begin
      $display("lru_key_value_cache_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/lruc_pkg.sv
hdl/lruc_if.sv
hdl/lruc_cell.sv
hdl/lruc_ctrl.sv
hdl/lru_key_value_cache.sv
verif/lru_key_value_cache_tb.sv
